// ===== rtl/dq_pkg.sv =====
// shared types and codes of the double-ended queue
`default_nettype none

package dq_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;

  // request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REVERSE    = 3'd4,
    ACT_PEEK       = 3'd5
  } act_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } stat_t;

  // per-cycle operation applied to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_SHIFT_UP   = 3'd1,
    CELL_SHIFT_DOWN = 3'd2,
    CELL_APPEND     = 3'd3,
    CELL_TRIM       = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dq_in_if.sv =====
// request channel of the double-ended queue
`default_nettype none

interface dq_in_if import dq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [ACTION_W-1:0]           action;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/dq_out_if.sv =====
// result channel of the double-ended queue
`default_nettype none

interface dq_out_if import dq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_W     = 5
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] front_value;
  logic signed [VALUE_WIDTH-1:0] back_value;
  logic [COUNT_W-1:0]            count;
  logic                          empty_res;
  logic [STATUS_W-1:0]           status;

  modport source (output valid, front_value, back_value, count, empty_res, status,
                  input ready);
  modport sink   (input valid, front_value, back_value, count, empty_res, status,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// top level of the double-ended queue: cell row, action decode and result register
//
// Bounded double-ended queue of DEPTH signed entries. Each request pushes at
// the front or back, pops from the front or back, reverses the order or just
// peeks, and yields one result with the front and back values, the count, an
// empty flag and a status (overflow for a push when full, underflow for a pop
// when empty; the request then changes nothing). Storage is a row of cells:
// the physical front sits in cell 0, a front push or pop shifts the whole row
// by one cell, a back push or pop touches only the cell at the occupied edge.
// Reverse toggles a flag that swaps which physical end is the logical front.
// A request first updates the cell row; then the front and back entries are
// picked out of the updated row into the result register once it is free.
// A new request is taken once the previous one has reached the result
// register, even while that result still waits on the output side. There is
// no clearing pass after reset; empty cells are never shown.
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                   accept;
  act_t                   act;
  logic                   full;
  logic                   empty;
  logic                   front_phys;
  cell_ctl_t              ctl;
  stat_t                  status_nxt;
  logic [CNT_W-1:0]       count_nxt;
  logic                   rev_nxt;

  logic [CNT_W-1:0]       count_r;
  logic                   rev_r;
  logic                   busy_r;
  stat_t                  status_r;

  logic [VALUE_WIDTH-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]       cell_valid;
  logic [DEPTH-1:0]       cell_last;

  logic [VALUE_WIDTH-1:0] phys_front;
  logic [VALUE_WIDTH-1:0] phys_back;
  logic                   out_load;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] front_r;
  logic [VALUE_WIDTH-1:0] back_r;
  logic [CNT_W-1:0]       out_count_r;
  logic                   empty_r;
  stat_t                  out_status_r;

  assign accept = in_ch.valid && in_ch.ready;
  assign act    = act_t'(in_ch.action);
  assign full   = cell_valid[DEPTH-1];
  assign empty  = !cell_valid[0];

  // action decode into one row operation
  always_comb begin
    ctl.op     = CELL_HOLD;
    status_nxt = STAT_OK;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    front_phys = 1'b0;
    if (accept) begin
      unique case (act) inside
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          front_phys = (act == ACT_PUSH_FRONT) != rev_r;
          if (full) begin
            status_nxt = STAT_OVERFLOW;
          end else begin
            ctl.op    = front_phys ? CELL_SHIFT_UP : CELL_APPEND;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          front_phys = (act == ACT_POP_FRONT) != rev_r;
          if (empty) begin
            status_nxt = STAT_UNDERFLOW;
          end else begin
            ctl.op    = front_phys ? CELL_SHIFT_DOWN : CELL_TRIM;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ACT_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
          ctl.op = CELL_HOLD;
        end
      endcase
    end
  end

  // row of cells, cell 0 holds the physical front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] l_data;
    logic                   l_valid;
    logic [VALUE_WIDTH-1:0] r_data;
    logic                   r_valid;

    if (i == 0) begin : g_head
      assign l_data  = in_ch.value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    dq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .push_data   (in_ch.value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .last        (cell_last[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
    end
  end

  // status of the request in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign in_ch.ready = !busy_r;

  // pick physical ends out of the updated row
  assign phys_front = cell_data[0] & {VALUE_WIDTH{cell_valid[0]}};
  always_comb begin
    phys_back = '0;
    for (int i = 0; i < DEPTH; i++) begin
      phys_back = phys_back | (cell_data[i] & {VALUE_WIDTH{cell_last[i]}});
    end
  end

  assign out_load = busy_r && (!out_valid_r || out_ch.ready);

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      front_r      <= rev_r ? phys_back : phys_front;
      back_r       <= rev_r ? phys_front : phys_back;
      out_count_r  <= count_r;
      empty_r      <= empty;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = $signed(front_r);
  assign out_ch.back_value  = $signed(back_r);
  assign out_ch.count       = out_count_r;
  assign out_ch.empty_res   = empty_r;
  assign out_ch.status      = out_status_r;

`ifndef NO_ASSERTIONS
  // entry count tracks the occupied cells
  a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(cell_valid)))
    else $error("count register disagrees with occupied cells");

  // occupied cells form one unbroken run from cell 0
  a_row_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("gap in the occupied cell row");

  // in the cycle after an accepted request, the next one is held off
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !in_ch.ready)
    else $error("request accepted while the previous one is in flight");

  // a result appears only for a request in flight
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a request");
`endif

endmodule

`default_nettype wire

// ===== rtl/dq_cell.sv =====
// one storage cell of the queue row, trading data with its two neighbors
`default_nettype none

module dq_cell import dq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_ctl_t              ctl,
  input  wire logic [VALUE_WIDTH-1:0] push_data,
  input  wire logic [VALUE_WIDTH-1:0] left_data,
  input  wire logic                   left_valid,
  input  wire logic [VALUE_WIDTH-1:0] right_data,
  input  wire logic                   right_valid,
  output logic      [VALUE_WIDTH-1:0] data,
  output logic                        valid,
  output logic                        last
);

  logic [VALUE_WIDTH-1:0] data_r;
  logic [VALUE_WIDTH-1:0] data_nxt;
  logic                   valid_r;
  logic                   valid_nxt;

  // next contents from the row operation
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (ctl.op)
      CELL_SHIFT_UP: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      CELL_SHIFT_DOWN: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      CELL_APPEND: begin
        // first free cell takes the new entry
        if (left_valid && !valid_r) begin
          data_nxt  = push_data;
          valid_nxt = 1'b1;
        end
      end
      CELL_TRIM: begin
        // last occupied cell lets go
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
        data_nxt  = data_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  // entry payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;
  assign last  = valid_r && !right_valid;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench of the double-ended queue: directed table, random episodes, scoreboard
`default_nettype none

module testbench;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VW         = 32;
  localparam int unsigned RAND_ITEMS = 600;
  localparam int unsigned PLAN_ROWS  = 23;

  // action codes outside the enum, decoded as peek
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [VW-1:0] front_v;
    logic signed [VW-1:0] back_v;
    logic [4:0]           fill;
    logic                 empty;
    stat_t                stat;
  } dq_result_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [VW-1:0]       val;
    logic                lit;
    dq_result_t          want;
  } plan_row_t;

  localparam dq_result_t EMPTY_OK    = '{32'sd0, 32'sd0, 5'd0, 1'b1, STAT_OK};
  localparam dq_result_t EMPTY_UNDER = '{32'sd0, 32'sd0, 5'd0, 1'b1, STAT_UNDERFLOW};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dq_in_if  #(.VALUE_WIDTH(VW))               in_ch ();
  dq_out_if #(.VALUE_WIDTH(VW), .COUNT_W(5))  out_ch ();

  double_ended_queue #(.DEPTH(DEPTH), .VALUE_WIDTH(VW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // directed table: empty cases, extremes, reverse, spare codes, wraparound
  plan_row_t plan [PLAN_ROWS] = '{
    '{ACT_PEEK,       32'h0,         1'b1, EMPTY_OK},
    '{ACT_POP_FRONT,  32'h1234_5678, 1'b1, EMPTY_UNDER},
    '{ACT_POP_BACK,   32'hffff_ffff, 1'b1, EMPTY_UNDER},
    '{ACT_REVERSE,    32'h0,         1'b1, EMPTY_OK},
    '{ACT_SPARE_LO,   32'hdead_beef, 1'b1, EMPTY_OK},
    '{ACT_SPARE_HI,   32'h0,         1'b1, EMPTY_OK},
    '{ACT_PUSH_FRONT, VAL_MAX,       1'b1, '{VAL_MAX, VAL_MAX, 5'd1, 1'b0, STAT_OK}},
    '{ACT_PUSH_BACK,  VAL_MIN,       1'b1, '{VAL_MAX, VAL_MIN, 5'd2, 1'b0, STAT_OK}},
    '{ACT_REVERSE,    32'h0,         1'b1, '{VAL_MIN, VAL_MAX, 5'd2, 1'b0, STAT_OK}},
    '{ACT_PUSH_FRONT, 32'hffff_ffff, 1'b1, '{-32'sd1, VAL_MAX, 5'd3, 1'b0, STAT_OK}},
    '{ACT_PUSH_BACK,  32'h0,         1'b0, '0},
    '{ACT_PEEK,       32'h5a5a_5a5a, 1'b0, '0},
    '{ACT_POP_FRONT,  32'h0,         1'b0, '0},
    '{ACT_POP_BACK,   32'h0,         1'b0, '0},
    '{ACT_REVERSE,    32'h0,         1'b0, '0},
    '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
    '{ACT_PUSH_BACK,  32'haaaa_aaaa, 1'b0, '0},
    '{ACT_POP_BACK,   32'h0,         1'b0, '0},
    '{ACT_POP_FRONT,  32'h0,         1'b0, '0},
    '{ACT_POP_FRONT,  32'h0,         1'b0, '0},
    '{ACT_POP_BACK,   32'h0,         1'b0, '0},
    '{ACT_POP_FRONT,  32'h0,         1'b0, '0},
    '{ACT_PEEK,       32'h0,         1'b1, EMPTY_OK}
  };

  // queue shadow: circular slots, head slot, fill level, direction flag
  logic signed [VW-1:0] dq_slots [DEPTH];
  logic [3:0]           dq_head;
  logic [4:0]           dq_fill;
  logic                 dq_flipped;

  dq_result_t pending_results [$];

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 59;
  int unsigned phase         = 0;
  int unsigned sent          = 0;
  int unsigned results_seen  = 0;
  int unsigned errors        = 0;
  int unsigned n_overflow    = 0;
  int unsigned n_underflow   = 0;
  int unsigned n_full        = 0;

  always #1 clk = ~clk;

  // apply one request to the shadow queue and return the result it should give
  function automatic dq_result_t apply_request(logic [ACTION_W-1:0] act,
                                               logic signed [VW-1:0] val);
    dq_result_t r;
    logic       at_phys_front;
    logic [3:0] tail;
    logic signed [VW-1:0] pf, pb;
    r      = '0;
    r.stat = STAT_OK;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (dq_fill == DEPTH) begin
          r.stat = STAT_OVERFLOW;
          n_overflow++;
        end else begin
          at_phys_front = (act == ACT_PUSH_FRONT) ^ dq_flipped;
          if (at_phys_front) begin
            dq_head = dq_head - 4'd1;
            dq_slots[dq_head] = val;
          end else begin
            tail = dq_head + dq_fill[3:0];
            dq_slots[tail] = val;
          end
          dq_fill++;
          if (dq_fill == DEPTH) n_full++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (dq_fill == 0) begin
          r.stat = STAT_UNDERFLOW;
          n_underflow++;
        end else begin
          at_phys_front = (act == ACT_POP_FRONT) ^ dq_flipped;
          if (at_phys_front) dq_head = dq_head + 4'd1;
          dq_fill--;
        end
      end
      ACT_REVERSE: dq_flipped = ~dq_flipped;
      default: ;
    endcase
    // front and back of the logical order; zero when empty
    if (dq_fill != 0) begin
      tail      = dq_head + dq_fill[3:0] - 4'd1;
      pf        = dq_slots[dq_head];
      pb        = dq_slots[tail];
      r.front_v = dq_flipped ? pb : pf;
      r.back_v  = dq_flipped ? pf : pb;
    end
    r.fill  = dq_fill;
    r.empty = (dq_fill == 0);
    return r;
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 22) return ACT_PUSH_FRONT;
    if (r < 44) return ACT_PUSH_BACK;
    if (r < 62) return ACT_POP_FRONT;
    if (r < 80) return ACT_POP_BACK;
    if (r < 90) return ACT_REVERSE;
    if (r < 96) return ACT_PEEK;
    if (r < 98) return ACT_SPARE_LO;
    return ACT_SPARE_HI;
  endfunction

  // extremes often, otherwise any 32-bit pattern
  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // drive one request, wait for its acceptance, record what it should produce
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [VW-1:0] val,
                              input logic lit, input dq_result_t want);
    dq_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = apply_request(act, val);
    pending_results.push_back(lit ? want : pred);
    sent++;
    @(negedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain_outstanding();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [VW-1:0] want,
                             input logic [VW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // result side: random stalls per phase
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // scoreboard: every accepted result against the oldest expectation
  always @(posedge clk) begin
    dq_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("front_value", exp_r.front_v, out_ch.front_value);
        check_field("back_value", exp_r.back_v, out_ch.back_value);
        check_field("count", 32'(exp_r.fill), 32'(out_ch.count));
        check_field("empty_res", 32'(exp_r.empty), 32'(out_ch.empty_res));
        check_field("status", 32'(exp_r.stat), 32'(out_ch.status));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned random_sent;
    int unsigned extra;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PEEK;
    in_ch.value  = '0;
    dq_head      = '0;
    dq_fill      = '0;
    dq_flipped   = 1'b0;
    foreach (dq_slots[i]) dq_slots[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (plan[i]) send_request(plan[i].act, plan[i].val, plan[i].lit, plan[i].want);
    drain_outstanding();

    // random episodes: fill to full, drain to empty, or a mixed run
    random_sent = 0;
    while (random_sent < RAND_ITEMS) begin
      if (random_sent >= 2 * RAND_ITEMS / 3 && phase != 2) begin
        drain_outstanding();
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_sent >= RAND_ITEMS / 3 && phase == 0) begin
        drain_outstanding();
        phase         = 1;
        send_idle_pct = 59;
        recv_idle_pct = 36;
      end
      case ($urandom_range(3))
        0: begin
          while (dq_fill < DEPTH) begin
            if ($urandom_range(5) == 0) send_request(ACT_REVERSE, pick_value(), 1'b0, '0);
            else send_request($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                              pick_value(), 1'b0, '0);
          end
          extra = $urandom_range(1, 2);
          repeat (extra) send_request($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                                      pick_value(), 1'b0, '0);
        end
        1: begin
          while (dq_fill != 0) begin
            if ($urandom_range(5) == 0) send_request(ACT_PEEK, pick_value(), 1'b0, '0);
            else send_request($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK,
                              pick_value(), 1'b0, '0);
          end
          extra = $urandom_range(1, 2);
          repeat (extra) send_request($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK,
                                      pick_value(), 1'b0, '0);
        end
        default: begin
          extra = $urandom_range(8, 24);
          repeat (extra) send_request(pick_action(), pick_value(), 1'b0, '0);
        end
      endcase
      random_sent = sent - PLAN_ROWS;
    end

    // wind down
    drain_outstanding();
    repeat (10) @(negedge clk);
    $display("%0d requests, %0d results checked", sent, results_seen);
    $display("full reached %0d times, %0d overflow, %0d underflow",
             n_full, n_overflow, n_underflow);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("double_ended_queue: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
